/* rtl/dor_pkg.sv */
package dor_pkg;

   // Address split, from the low end: column, row, bank, rank.
   localparam int COL_BITS    = 10;
   localparam int ROW_BITS    = 6;
   localparam int BANK_BITS   = 3;
   localparam int RANK_BITS   = 1;
   localparam int BURST_BYTES = 8;

   localparam int TOTAL_BITS  = COL_BITS + ROW_BITS + BANK_BITS + RANK_BITS;
   localparam int TAG_BITS    = BANK_BITS + RANK_BITS;
   localparam int TAG_COUNT   = 1 << TAG_BITS;

   // Payload widths.
   localparam int ADDR_W      = 20;
   localparam int LEN_W       = 3;
   localparam int DATA_W      = 32;
   localparam int DATA_BYTES  = DATA_W / 8;

   // Memory words are one burst wide.
   localparam int WORD_BYTES  = BURST_BYTES;
   localparam int WORD_W      = WORD_BYTES * 8;
   localparam int OFFS_W      = $clog2(WORD_BYTES);
   localparam int WORD_AW     = TOTAL_BITS - OFFS_W;
   localparam int WORD_COUNT  = 1 << WORD_AW;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic access0;
      logic access1;
      logic capture_lo;
      logic load_rsp;
   } dor_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic crossed;
      logic out_of_range;
      logic rsp_free;
   } dor_status_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_ACC0 = 4'b0010,
      ST_ACC1 = 4'b0100,
      ST_DONE = 4'b1000
   } dor_state_type;

endpackage

/* rtl/dor_ram.sv */
module dor_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [WIDTH/8-1:0]       be,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Byte-masked write; the read register holds until the next read.
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            for (int b = 0; b < WIDTH / 8; b++) begin
               if (be[b]) begin
                  mem_ff[addr][b*8 +: 8] <= wdata[b*8 +: 8];
               end
            end
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/dor_ctrl.sv */
module dor_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  dor_pkg::dor_status_type status,
   output dor_pkg::dor_cmd_type    cmd,
   output logic                    ready
);

   import dor_pkg::*;

   dor_state_type state_ff;
   dor_state_type state_in;
   logic          accept;

   always_comb begin
      cmd      = '0;
      ready    = 1'b0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            ready = 1'b1;
         end
         ST_ACC0: begin
            if (status.out_of_range) begin
               state_in = ST_DONE;
            end else begin
               cmd.access0 = 1'b1;
               state_in    = status.crossed ? ST_ACC1 : ST_DONE;
            end
         end
         ST_ACC1: begin
            cmd.access1    = 1'b1;
            cmd.capture_lo = 1'b1;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               ready        = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      accept = ready && req_valid;
      if (accept) begin
         cmd.load_req = 1'b1;
         state_in     = ST_ACC0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/dor_datapath.sv */
module dor_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  dor_pkg::dor_cmd_type       cmd,
   output dor_pkg::dor_status_type    status,
   input  logic                       req_op,
   input  logic [dor_pkg::ADDR_W-1:0] req_address,
   input  logic [dor_pkg::LEN_W-1:0]  req_length,
   input  logic [dor_pkg::DATA_W-1:0] req_write_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [dor_pkg::DATA_W-1:0] rsp_read_data,
   output logic                       rsp_first_row_hit,
   output logic                       rsp_second_row_hit,
   output logic                       rsp_crossed,
   output logic                       rsp_out_of_range
);

   import dor_pkg::*;

   localparam int EXT_W  = ADDR_W + 1;
   localparam int WIDE_W = WORD_W + DATA_W;

   // Request registers.
   logic              op_ff, op_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [DATA_W-1:0] wdata_ff, wdata_in;

   // Open-row tags.
   logic                tag_valid_ff [TAG_COUNT];
   logic                tag_valid_in [TAG_COUNT];
   logic [ROW_BITS-1:0] tag_row_ff [TAG_COUNT];
   logic [ROW_BITS-1:0] tag_row_in [TAG_COUNT];

   logic              hit0_ff, hit0_in;
   logic              hit1_ff, hit1_in;
   logic [WORD_W-1:0] lo_ff, lo_in;

   // Result register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_hit0_ff, rsp_hit0_in;
   logic              rsp_hit1_ff, rsp_hit1_in;
   logic              rsp_crossed_ff, rsp_crossed_in;
   logic              rsp_oor_ff, rsp_oor_in;

   logic [LEN_W-1:0]          len_c;
   logic [OFFS_W-1:0]         offset;
   logic [EXT_W-1:0]          first_ext;
   logic [EXT_W-1:0]          second_ext;
   logic [ADDR_W-1:0]         acc_addr;
   logic                      crossed;
   logic                      first_oor;
   logic                      second_oor;
   logic                      oor;
   logic [DATA_BYTES-1:0]     len_mask;
   logic [WORD_BYTES+DATA_BYTES-1:0] byte_mask;
   logic [WIDE_W-1:0]         wide_data;
   logic [WORD_AW-1:0]        word0;
   logic [WORD_AW-1:0]        ram_addr;
   logic [WORD_BYTES-1:0]     ram_be;
   logic [WORD_W-1:0]         ram_wdata;
   logic [WORD_W-1:0]         ram_rdata;
   logic                      ram_en;
   logic [TAG_BITS-1:0]       tag_idx;
   logic [ROW_BITS-1:0]       tag_row;
   logic                      hit;
   logic [2*WORD_W-1:0]       pair;
   logic [2*WORD_W-1:0]       shifted;
   logic [DATA_W-1:0]         data_mask;

   // Request decode.
   always_comb begin
      len_c = len_ff;
      if (len_ff == '0) begin
         len_c = LEN_W'(1);
      end else if (len_ff > LEN_W'(DATA_BYTES)) begin
         len_c = LEN_W'(DATA_BYTES);
      end
      case (len_c)
         LEN_W'(1): len_mask = 4'b0001;
         LEN_W'(2): len_mask = 4'b0011;
         LEN_W'(3): len_mask = 4'b0111;
         default:   len_mask = 4'b1111;
      endcase
   end

   assign offset     = addr_ff[OFFS_W-1:0];
   assign first_ext  = {1'b0, addr_ff[ADDR_W-1:OFFS_W], {OFFS_W{1'b0}}};
   assign second_ext = first_ext + EXT_W'(BURST_BYTES);
   assign crossed    = ({1'b0, offset} + (OFFS_W+1)'(len_c)) > (OFFS_W+1)'(BURST_BYTES);
   assign first_oor  = (first_ext >> TOTAL_BITS) != '0;
   assign second_oor = (second_ext >> TOTAL_BITS) != '0;
   assign oor        = first_oor || (crossed && second_oor);

   assign status.crossed      = crossed;
   assign status.out_of_range = oor;
   assign status.rsp_free     = !rsp_valid_ff || !rsp_stall;

   // Memory access for the first or the second burst.
   assign byte_mask = {{WORD_BYTES{1'b0}}, len_mask} << offset;
   assign wide_data = {{WORD_W{1'b0}}, wdata_ff} << {offset, 3'b000};
   assign word0     = addr_ff[TOTAL_BITS-1:OFFS_W];
   assign ram_en    = cmd.access0 || cmd.access1;
   assign ram_addr  = cmd.access1 ? word0 + WORD_AW'(1) : word0;
   assign ram_be    = cmd.access1
                      ? WORD_BYTES'(byte_mask[WORD_BYTES +: DATA_BYTES])
                      : byte_mask[WORD_BYTES-1:0];
   assign ram_wdata = cmd.access1
                      ? WORD_W'(wide_data[WORD_W +: DATA_W])
                      : wide_data[WORD_W-1:0];

   dor_ram #(
      .WIDTH (WORD_W),
      .DEPTH (WORD_COUNT)
   ) u_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (op_ff),
      .be    (ram_be),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Open-row check and update for the burst being accessed.
   assign acc_addr = cmd.access1 ? second_ext[ADDR_W-1:0] : addr_ff;
   assign tag_idx  = acc_addr[COL_BITS + ROW_BITS +: TAG_BITS];
   assign tag_row  = acc_addr[COL_BITS +: ROW_BITS];
   assign hit      = tag_valid_ff[tag_idx] && (tag_row_ff[tag_idx] == tag_row);

   always_comb begin
      tag_valid_in = tag_valid_ff;
      tag_row_in   = tag_row_ff;
      if (ram_en) begin
         tag_valid_in[tag_idx] = 1'b1;
         tag_row_in[tag_idx]   = tag_row;
      end
   end

   assign hit0_in = cmd.access0 ? hit : hit0_ff;
   assign hit1_in = cmd.access1 ? hit : hit1_ff;
   assign lo_in   = cmd.capture_lo ? ram_rdata : lo_ff;

   assign op_in    = cmd.load_req ? req_op         : op_ff;
   assign addr_in  = cmd.load_req ? req_address    : addr_ff;
   assign len_in   = cmd.load_req ? req_length     : len_ff;
   assign wdata_in = cmd.load_req ? req_write_data : wdata_ff;

   // Read data assembly.
   assign pair    = crossed ? {ram_rdata, lo_ff} : {{WORD_W{1'b0}}, ram_rdata};
   assign shifted = pair >> {offset, 3'b000};

   always_comb begin
      for (int b = 0; b < DATA_BYTES; b++) begin
         data_mask[b*8 +: 8] = {8{len_mask[b]}};
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      rsp_hit0_in    = rsp_hit0_ff;
      rsp_hit1_in    = rsp_hit1_ff;
      rsp_crossed_in = rsp_crossed_ff;
      rsp_oor_in     = rsp_oor_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in   = 1'b1;
         rsp_oor_in     = oor;
         rsp_crossed_in = first_oor ? 1'b0 : crossed;
         rsp_hit0_in    = !oor && hit0_ff;
         rsp_hit1_in    = !oor && crossed && hit1_ff;
         rsp_data_in    = (oor || op_ff) ? '0 : (shifted[DATA_W-1:0] & data_mask);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int t = 0; t < TAG_COUNT; t++) begin
            tag_valid_ff[t] <= 1'b0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         tag_valid_ff <= tag_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      addr_ff        <= addr_in;
      len_ff         <= len_in;
      wdata_ff       <= wdata_in;
      tag_row_ff     <= tag_row_in;
      hit0_ff        <= hit0_in;
      hit1_ff        <= hit1_in;
      lo_ff          <= lo_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_hit0_ff    <= rsp_hit0_in;
      rsp_hit1_ff    <= rsp_hit1_in;
      rsp_crossed_ff <= rsp_crossed_in;
      rsp_oor_ff     <= rsp_oor_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = rsp_data_ff;
   assign rsp_first_row_hit  = rsp_hit0_ff;
   assign rsp_second_row_hit = rsp_hit1_ff;
   assign rsp_crossed        = rsp_crossed_ff;
   assign rsp_out_of_range   = rsp_oor_ff;

endmodule

/* rtl/dram_open_row_memory_unit.sv */
// An item passes through the controller states ACC0 and DONE, or ACC0, ACC1 and DONE when it
// spans two bursts (one access of the single-port word memory per burst); the result register
// is loaded in DONE once the result side is free. A new item is taken in IDLE or in that load,
// but not while an item is in ACC0 or ACC1; the single memory port sets this pace.
// Reset clears the controller, the result valid flag and the open-row valid bits at once;
// the word memory is not cleared and must be written before it is read.
module dram_open_row_memory_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_op,
   input  logic [dor_pkg::ADDR_W-1:0] req_address,
   input  logic [dor_pkg::LEN_W-1:0]  req_length,
   input  logic [dor_pkg::DATA_W-1:0] req_write_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [dor_pkg::DATA_W-1:0] rsp_read_data,
   output logic                       rsp_first_row_hit,
   output logic                       rsp_second_row_hit,
   output logic                       rsp_crossed,
   output logic                       rsp_out_of_range
);

   import dor_pkg::*;

   // The controller steps each item through its burst accesses. The datapath holds the
   // request, the open-row tags, the word memory and the result register, so a new item
   // can be taken while the previous result still waits for the receiver.
   dor_cmd_type    cmd;
   dor_status_type status;
   logic           ready;

   dor_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .cmd       (cmd),
      .ready     (ready)
   );

   dor_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_op             (req_op),
      .req_address        (req_address),
      .req_length         (req_length),
      .req_write_data     (req_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_data      (rsp_read_data),
      .rsp_first_row_hit  (rsp_first_row_hit),
      .rsp_second_row_hit (rsp_second_row_hit),
      .rsp_crossed        (rsp_crossed),
      .rsp_out_of_range   (rsp_out_of_range)
   );

   // An item is taken whenever the controller can start it.
   assign req_stall = !ready;

endmodule

/* dv/dram_open_row_memory_unit_tb.sv */
`timescale 1ns / 1ps

module dram_open_row_memory_unit_tb;
   import dor_pkg::*;

   // Memory size in bytes and the aligned address of the highest burst.
   localparam int unsigned MEM_BYTES = 1 << TOTAL_BITS;
   localparam int unsigned TOP_BURST = MEM_BYTES - BURST_BYTES;

   // Random items after the directed ones.
   localparam int RANDOM_ITEMS = 1200;

   // The slowest correct run has about 1230 items. Each item passes through the controller
   // states of the block, may follow a random sender gap and may wait on result stalls in the
   // heaviest stall pattern; this limit is generous for all of that.
   localparam int CYCLE_LIMIT = 400000;

   // Cycles to watch the result port after the last expected item has arrived. A stray result
   // would show up well within them.
   localparam int DRAIN_CYCLES = 12;

   typedef enum bit {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } access_op_type;

   // Patterns that the result side uses to stall.
   typedef enum int unsigned {
      STALL_NONE,
      STALL_COIN,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_pattern_type;

   typedef struct {
      access_op_type       op;
      logic [ADDR_W-1:0]   address;
      logic [LEN_W-1:0]    length;
      logic [DATA_W-1:0]   write_data;
   } dram_request_type;

   typedef struct {
      logic [DATA_W-1:0]   read_data;
      logic                first_row_hit;
      logic                second_row_hit;
      logic                crossed;
      logic                out_of_range;
   } dram_result_type;

   // A run of bytes that a performed write has defined.
   typedef struct {
      int unsigned address;
      int unsigned byte_total;
   } written_span_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_op = 1'b0;
   logic [ADDR_W-1:0]   req_address = '0;
   logic [LEN_W-1:0]    req_length = '0;
   logic [DATA_W-1:0]   req_write_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [DATA_W-1:0]   rsp_read_data;
   logic                rsp_first_row_hit;
   logic                rsp_second_row_hit;
   logic                rsp_crossed;
   logic                rsp_out_of_range;

   // Predicted state of the block: memory contents by byte address and the open row of
   // each rank and bank. The open-row marks start clear, as after reset.
   logic [7:0]          byte_store [int unsigned];
   logic [ROW_BITS-1:0] open_row [TAG_COUNT];
   bit                  row_is_open [TAG_COUNT];

   // Bytes that the items queued so far will have written. Reads are only generated over
   // these, since reading a byte that was never written is not allowed.
   bit                  gen_written [int unsigned];
   written_span_type    written_spans [$];
   int unsigned         last_address = 0;

   dram_request_type    pending_requests [$];
   dram_result_type     expected_results [$];
   dram_request_type    in_flight;

   int                  total_requests = 0;
   int                  accepted_requests = 0;
   int                  error_count = 0;
   int                  cycle_count = 0;
   int unsigned         burst_left = 8;
   int unsigned         gap_left = 0;
   stall_pattern_type   stall_mode = STALL_NONE;
   int unsigned         stall_hold = 100;

   dram_open_row_memory_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_address        (req_address),
      .req_length         (req_length),
      .req_write_data     (req_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_data      (rsp_read_data),
      .rsp_first_row_hit  (rsp_first_row_hit),
      .rsp_second_row_hit (rsp_second_row_hit),
      .rsp_crossed        (rsp_crossed),
      .rsp_out_of_range   (rsp_out_of_range)
   );

   always #5 clock = ~clock;

   // A length of zero acts as one byte and anything above four as four bytes.
   function automatic int unsigned byte_count(logic [LEN_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > 4) return 4;
      return int'(raw);
   endfunction

   // An access is refused when its first burst, or its second burst if it crosses, lies
   // past the end of memory.
   function automatic bit lands_out_of_range(int unsigned addr, int unsigned n);
      int unsigned offs;
      int unsigned first;
      offs = addr % BURST_BYTES;
      first = addr - offs;
      if (first >= MEM_BYTES) return 1'b1;
      return (offs + n > BURST_BYTES) && (first + BURST_BYTES >= MEM_BYTES);
   endfunction

   // Looks up the open row for the burst at this aligned address and opens its row.
   function automatic bit check_row(int unsigned burst_addr);
      int unsigned         t;
      logic [ROW_BITS-1:0] row;
      bit                  hit;
      t = (burst_addr >> (COL_BITS + ROW_BITS)) % TAG_COUNT;
      row = ROW_BITS'(burst_addr >> COL_BITS);
      hit = row_is_open[t] && open_row[t] == row;
      open_row[t] = row;
      row_is_open[t] = 1'b1;
      return hit;
   endfunction

   // Works out the result of one accepted item and applies its effect on the state.
   function automatic dram_result_type predict_access(dram_request_type rq);
      dram_result_type res;
      int unsigned     n;
      int unsigned     offs;
      int unsigned     first;
      bit              crosses;
      res = '{default: '0};
      n = byte_count(rq.length);
      offs = rq.address % BURST_BYTES;
      first = rq.address - offs;
      crosses = (offs + n) > BURST_BYTES;
      if (lands_out_of_range(rq.address, n)) begin
         // Nothing is performed: no row is opened and no byte changes.
         res.crossed = (first < MEM_BYTES) && crosses;
         res.out_of_range = 1'b1;
      end else begin
         res.first_row_hit = check_row(first);
         if (crosses) res.second_row_hit = check_row(first + BURST_BYTES);
         res.crossed = crosses;
         for (int i = 0; i < n; i++) begin
            if (rq.op == OP_WRITE) begin
               byte_store[rq.address + i] = rq.write_data[8*i +: 8];
            end else if (byte_store.exists(rq.address + i)) begin
               res.read_data[8*i +: 8] = byte_store[rq.address + i];
            end
         end
      end
      return res;
   endfunction

   // Appends one item and records which bytes it will define.
   task automatic queue_request(access_op_type op, int unsigned addr, int unsigned raw_len,
                                logic [DATA_W-1:0] data);
      dram_request_type rq;
      int unsigned      n;
      rq.op = op;
      rq.address = ADDR_W'(addr % MEM_BYTES);
      rq.length = LEN_W'(raw_len);
      rq.write_data = data;
      pending_requests.push_back(rq);
      n = byte_count(rq.length);
      if (op == OP_WRITE && !lands_out_of_range(rq.address, n)) begin
         for (int i = 0; i < n; i++) gen_written[rq.address + i] = 1'b1;
         written_spans.push_back('{rq.address, n});
      end
   endtask

   // Mostly near the previous address or inside a few rows per bank, so that rows stay
   // open and hits are common; the rest spreads over the whole address range.
   function automatic int unsigned pick_address();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
         last_address = (last_address + $urandom_range(0, 63) - 32) % MEM_BYTES;
      end else if (sel < 75) begin
         last_address = ($urandom_range(0, TAG_COUNT - 1) << (COL_BITS + ROW_BITS))
                      | ($urandom_range(0, 3) << COL_BITS)
                      | $urandom_range(0, (1 << COL_BITS) - 1);
      end else begin
         last_address = $urandom_range(0, MEM_BYTES - 1);
      end
      return last_address;
   endfunction

   // Recently written spans are favored, since their rows are likely still open.
   function automatic written_span_type pick_span();
      int unsigned depth;
      depth = written_spans.size();
      if (depth > 16 && $urandom_range(0, 9) < 7)
         return written_spans[depth - 1 - $urandom_range(0, 15)];
      return written_spans[$urandom_range(0, depth - 1)];
   endfunction

   // Encodes a byte count, sometimes as one of the lengths that the block clamps.
   function automatic int unsigned raw_length(int unsigned n);
      if (n == 1 && $urandom_range(0, 1) == 1) return 0;
      if (n == 4) return $urandom_range(4, 7);
      return n;
   endfunction

   // Queues a read of written bytes only, or a write while none is written yet. A shifted
   // window over a written span is tried first, else the read lies in a single span.
   task automatic queue_read();
      written_span_type span;
      int unsigned      a;
      int unsigned      n;
      bit               covered;
      if (written_spans.size() == 0) begin
         queue_request(OP_WRITE, pick_address(), $urandom_range(0, 7), $urandom);
         return;
      end
      for (int k = 0; k < 6; k++) begin
         span = pick_span();
         a = (span.address + $urandom_range(0, 6) - 3) % MEM_BYTES;
         n = $urandom_range(1, 4);
         covered = 1'b1;
         for (int i = 0; i < n; i++)
            if (a + i < MEM_BYTES && !gen_written.exists(a + i)) covered = 1'b0;
         if (covered) begin
            queue_request(OP_READ, a, raw_length(n), $urandom);
            return;
         end
      end
      span = pick_span();
      a = span.address + $urandom_range(0, span.byte_total - 1);
      n = $urandom_range(1, span.address + span.byte_total - a);
      queue_request(OP_READ, a, raw_length(n), $urandom);
   endtask

   task automatic check_field(string field, logic [DATA_W-1:0] want_v,
                              logic [DATA_W-1:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want_v, got_v);
         error_count++;
      end
   endtask

   // Driver. Items go out in bursts of random length with random gaps in between. An item
   // is predicted at the edge where it is accepted, so the expected results follow the
   // order in which the block sees the items.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(predict_access(in_flight));
            accepted_requests++;
         end
         // A stalled item is held as it is; a new one is only presented once the
         // previous one has gone.
         if (!req_valid || !req_stall) begin
            if (gap_left > 0 || pending_requests.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               in_flight = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_op <= in_flight.op;
               req_address <= in_flight.address;
               req_length <= in_flight.length;
               req_write_data <= in_flight.write_data;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // Monitor. Each accepted result is checked against the oldest expectation. The stall
   // pattern is picked anew at random intervals and includes stretches without any stall.
   always @(posedge clock) begin : result_monitor
      dram_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result with no item outstanding: expected none, actual %h",
                        $time, rsp_read_data);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("read_data", want.read_data, rsp_read_data);
               check_field("first_row_hit", DATA_W'(want.first_row_hit),
                           DATA_W'(rsp_first_row_hit));
               check_field("second_row_hit", DATA_W'(want.second_row_hit),
                           DATA_W'(rsp_second_row_hit));
               check_field("crossed", DATA_W'(want.crossed), DATA_W'(rsp_crossed));
               check_field("out_of_range", DATA_W'(want.out_of_range),
                           DATA_W'(rsp_out_of_range));
            end
         end
         if (stall_hold == 0) begin
            stall_mode = stall_pattern_type'($urandom_range(0, 3));
            stall_hold = $urandom_range(50, 300);
         end else begin
            stall_hold--;
         end
         case (stall_mode)
            STALL_NONE: begin
               rsp_stall <= 1'b0;
            end
            STALL_COIN: begin
               rsp_stall <= 1'($urandom_range(0, 1));
            end
            STALL_PERIODIC: begin
               rsp_stall <= (cycle_count % 3) != 0;
            end
            default: begin
               rsp_stall <= $urandom_range(0, 9) < 8;
            end
         endcase
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d items outstanding", $time, expected_results.size());
         $display("dram_open_row_memory_unit_tb: FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned offs;
      int unsigned sel;

      // Directed items. First the lowest address, all ones: a row miss, then a hit.
      queue_request(OP_WRITE, 0, 4, 32'hFFFF_FFFF);
      queue_request(OP_READ, 0, 4, 32'h0);
      // Fill the highest burst of memory, then read the very last byte.
      queue_request(OP_WRITE, TOP_BURST + 4, 4, 32'h1234_5678);
      queue_request(OP_WRITE, TOP_BURST, 4, 32'hA5C3_0F96);
      queue_request(OP_READ, MEM_BYTES - 1, 1, 32'h0);
      // Accesses that would need a burst past the end of memory are refused, both a
      // read and a write; the following read shows that the write changed nothing.
      queue_request(OP_READ, TOP_BURST + 5, 4, 32'h0);
      queue_request(OP_WRITE, TOP_BURST + 6, 3, 32'hFFFF_FFFF);
      queue_request(OP_READ, TOP_BURST + 4, 4, 32'h0);
      // A crossing access whose second burst starts the next row of the same bank.
      queue_request(OP_WRITE, (1 << COL_BITS) - 2, 4, 32'h0000_0000);
      queue_request(OP_READ, (1 << COL_BITS) - 2, 4, 32'h0);
      // A crossing access whose second burst lies in the next bank.
      queue_request(OP_WRITE, (1 << (COL_BITS + ROW_BITS)) - 3, 4, 32'h8765_4321);
      queue_request(OP_READ, (1 << (COL_BITS + ROW_BITS)) - 3, 4, 32'h0);
      // A crossing access whose second burst lies in the next rank.
      queue_request(OP_WRITE, (1 << (TOTAL_BITS - RANK_BITS)) - 1, 2, 32'hFFFF_CAFE);
      queue_request(OP_READ, (1 << (TOTAL_BITS - RANK_BITS)) - 1, 2, 32'h0);
      // A length of zero acts as a single byte.
      queue_request(OP_WRITE, 20'h12345, 0, 32'hFFFF_FFAB);
      queue_request(OP_READ, 20'h12345, 0, 32'hFFFF_FFFF);
      // Lengths above four act as four bytes.
      queue_request(OP_WRITE, 20'h54320, 7, 32'hDEAD_BEEF);
      queue_request(OP_READ, 20'h54320, 5, 32'h0);
      queue_request(OP_READ, 20'h54321, 3, 32'h0);
      queue_request(OP_READ, 20'h54320, 6, 32'h0);
      // Short reads inside the first item, then an overwrite of a single byte.
      queue_request(OP_READ, 1, 3, 32'h0);
      queue_request(OP_WRITE, 0, 1, 32'h0);
      queue_request(OP_READ, 0, 2, 32'h0);

      // Random items: writes and reads in about equal numbers, plus a few that run past
      // the end of memory.
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         sel = $urandom_range(0, 99);
         if (sel < 3) begin
            offs = $urandom_range(5, 7);
            queue_request(access_op_type'($urandom_range(0, 1)), TOP_BURST + offs,
                          $urandom_range(9 - offs, 7), $urandom);
         end else if (sel < 48) begin
            queue_request(OP_WRITE, pick_address(), $urandom_range(0, 7), $urandom);
         end else begin
            queue_read();
         end
      end
      total_requests = pending_requests.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Every item has gone in and every expected result has come back.
      while (accepted_requests < total_requests || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("dram_open_row_memory_unit_tb: PASS");
      end else begin
         $display("dram_open_row_memory_unit_tb: FAIL");
      end
      $finish;
   end

endmodule
